// ===== hdl/gdc_pkg.sv =====
// Shared types, constants and calendar tables for the Gregorian date counter.
`timescale 1ns / 1ps

package gdc_pkg;

  // Field widths
  localparam int DAY_W  = 5;
  localparam int MON_W  = 4;
  localparam int YEAR_W = 14;
  localparam int CNT_W  = 16;
  localparam int DIST_W = 22;
  localparam int DN_W   = 23;   // day number, 1/1/1 is day 1
  localparam int YR_W   = 15;   // working year, one above the largest stored year
  localparam int STEP_W = 20;
  localparam int Q_W    = 9;    // year / 100
  localparam int REM_W  = 9;    // day within year

  // Range limits
  localparam int MAX_STEP = 65535;
  localparam int MAX_YEAR = 9999;

  localparam int DAYS_YEAR = 365;
  localparam int DAYS_LEAP = 366;
  localparam int MONTHS    = 12;

  localparam logic [STEP_W-1:0] STEP_LIM = STEP_W'(MAX_STEP);
  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  // Day number of 31/12/MAX_YEAR
  localparam int DN_TOP_I = MAX_YEAR * DAYS_YEAR + MAX_YEAR / 4 - MAX_YEAR / 100
                          + MAX_YEAR / 400;
  localparam logic [DN_W-1:0] DN_TOP = DN_W'(DN_TOP_I);

  // Reciprocals: y / 100 = (y * RECIP_100) >> 20, exact for y < 43690
  localparam int RECIP_100_W  = 14;
  localparam int RECIP_100_SH = 20;
  localparam logic [RECIP_100_W-1:0] RECIP_100 = 14'd10486;
  // Years from a day count: n / 365.2425 ~ (n * RECIP_YR) >> 24, slightly low
  localparam int RECIP_YR_W  = 16;
  localparam int RECIP_YR_SH = 24;
  localparam logic [RECIP_YR_W-1:0] RECIP_YR = 16'd45934;

  // Reset date
  localparam logic [DAY_W-1:0]  RST_DAY   = 5'd1;
  localparam logic [MON_W-1:0]  RST_MONTH = 4'd1;
  localparam logic [YEAR_W-1:0] RST_YEAR  = 14'd2000;

  // Status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_RANGE   = 2'd2;

  typedef enum logic [1:0] {
    MODE_LOAD,
    MODE_ADVANCE,
    MODE_BACK,
    MODE_DISTANCE
  } mode_t;

  typedef enum logic [2:0] {
    YR_HOLD,
    YR_IN,
    YR_CUR,
    YR_EST,
    YR_INC,
    YR_DEC
  } yr_op_t;

  // Controller to datapath
  typedef struct packed {
    logic   latch_in;
    yr_op_t yr_op;
    logic   cap_b;
    logic   cap_a;
    logic   decide;
    logic   est_mul;
    logic   month_init;
    logic   month_step;
    logic   publish;
  } gdc_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_move;
    logic found;
    logic month_done;
  } gdc_stat_t;

  function automatic logic [DAY_W-1:0] month_days(input logic [MON_W-1:0] m,
                                                  input logic leap);
    logic [DAY_W-1:0] n;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    n = 5'd30;
      4'd2:                                       n = leap ? 5'd29 : 5'd28;
      default:                                    n = 5'd0;
    endcase
    return n;
  endfunction

  // Days in the months before month m of a common year
  function automatic logic [REM_W-1:0] days_before_month(input logic [MON_W-1:0] m);
    logic [REM_W-1:0] n;
    case (m)
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

endpackage

// ===== hdl/gdc_ctrl.sv =====
// Sequencer for the Gregorian date counter: walks each command through the datapath.
`timescale 1ns / 1ps

module gdc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_stall,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output gdc_pkg::gdc_cmd_t   cmd,
  input  gdc_pkg::gdc_stat_t  stat
);
  import gdc_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE,
    S_IN_W1,
    S_IN_W2,
    S_IN_USE,
    S_CUR_W1,
    S_CUR_W2,
    S_CUR_USE,
    S_DECIDE,
    S_EST,
    S_EST_YR,
    S_SRCH_W1,
    S_SRCH_W2,
    S_SRCH_CHK,
    S_YR_W1,
    S_YR_W2,
    S_YR_USE,
    S_MONTH,
    S_DONE
  } state_t;

  state_t state, state_next;
  logic   rsp_free;

  assign rsp_free  = !rsp_valid || !rsp_stall;
  assign cmd_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.yr_op  = YR_HOLD;
    case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd.latch_in = 1'b1;
          cmd.yr_op    = YR_IN;
          state_next   = S_IN_W1;
        end
      end
      S_IN_W1:  state_next = S_IN_W2;
      S_IN_W2:  state_next = S_IN_USE;
      S_IN_USE: begin
        cmd.cap_b  = 1'b1;
        cmd.yr_op  = YR_CUR;
        state_next = S_CUR_W1;
      end
      S_CUR_W1:  state_next = S_CUR_W2;
      S_CUR_W2:  state_next = S_CUR_USE;
      S_CUR_USE: begin
        cmd.cap_a  = 1'b1;
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        state_next = stat.is_move ? S_EST : S_DONE;
      end
      S_EST: begin
        cmd.est_mul = 1'b1;
        state_next  = S_EST_YR;
      end
      S_EST_YR: begin
        cmd.yr_op  = YR_EST;
        state_next = S_SRCH_W1;
      end
      S_SRCH_W1: state_next = S_SRCH_W2;
      S_SRCH_W2: state_next = S_SRCH_CHK;
      S_SRCH_CHK: begin
        if (stat.found) begin
          cmd.yr_op  = YR_DEC;
          state_next = S_YR_W1;
        end else begin
          cmd.yr_op  = YR_INC;
          state_next = S_SRCH_W1;
        end
      end
      S_YR_W1:  state_next = S_YR_W2;
      S_YR_W2:  state_next = S_YR_USE;
      S_YR_USE: begin
        cmd.month_init = 1'b1;
        state_next     = S_MONTH;
      end
      S_MONTH: begin
        cmd.month_step = 1'b1;
        if (stat.month_done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (rsp_free) begin
          cmd.publish = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.publish) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && !cmd_stall) |=> cmd_stall)
    else $error("accepted word did not make the sequencer busy");

  a_rsp_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state == S_DONE))
    else $error("response raised outside the done step");

  a_no_clobber: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_stall) |-> !cmd.publish)
    else $error("waiting response overwritten");

endmodule

// ===== hdl/gdc_datapath.sv =====
// Datapath of the Gregorian date counter: stored date, year unit, day-number arithmetic.
`timescale 1ns / 1ps

module gdc_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  gdc_pkg::gdc_cmd_t                 cmd,
  output gdc_pkg::gdc_stat_t                stat,
  input  logic [1:0]                        mode,
  input  logic [gdc_pkg::DAY_W-1:0]         in_day,
  input  logic [gdc_pkg::MON_W-1:0]         in_month,
  input  logic [gdc_pkg::YEAR_W-1:0]        in_year,
  input  logic [gdc_pkg::CNT_W-1:0]         step_count,
  output logic [gdc_pkg::DAY_W-1:0]         date_day,
  output logic [gdc_pkg::MON_W-1:0]         date_month,
  output logic [gdc_pkg::YEAR_W-1:0]        date_year,
  output logic [gdc_pkg::DIST_W-1:0]        distance,
  output logic [1:0]                        status
);
  import gdc_pkg::*;

  localparam int QP_W  = YR_W + RECIP_100_W;
  localparam int EP_W  = DN_W + RECIP_YR_W;
  localparam int SUM_W = DN_W + 1;

  function automatic logic [DN_W-1:0] day_number(input logic [DN_W-1:0]  base,
                                                 input logic [MON_W-1:0] m,
                                                 input logic [DAY_W-1:0] d,
                                                 input logic             leap);
    return base + DN_W'(days_before_month(m)) + DN_W'(leap && (m > 4'd2)) + DN_W'(d);
  endfunction

  // Stored date
  logic [DAY_W-1:0]  cur_day;
  logic [MON_W-1:0]  cur_month;
  logic [YEAR_W-1:0] cur_year;

  // Latched command word
  mode_t             mode_r;
  logic [DAY_W-1:0]  d_r;
  logic [MON_W-1:0]  m_r;
  logic [YEAR_W-1:0] y_r;
  logic [CNT_W-1:0]  cnt_r;

  // Year unit
  logic [YR_W-1:0] yr;
  logic [QP_W-1:0] qprod;
  logic [Q_W-1:0]  q;
  logic [YR_W-1:0] r;
  logic            zr;
  logic [Q_W-1:0]  p100;
  logic [YR_W-1:0] p;
  logic [DN_W-1:0] dby_c;
  logic            leap_c;
  logic [DN_W-1:0] dby_r;
  logic            leap_r;

  // Day numbers and results
  logic [DN_W-1:0]   a_r;
  logic [DN_W-1:0]   b_r;
  logic              vld_r;
  logic [DN_W-1:0]   dn;
  logic [EP_W-1:0]   eprod;
  logic [REM_W-1:0]  rem;
  logic [MON_W-1:0]  mo;
  logic              leap_m;
  logic [DAY_W-1:0]  nd;
  logic [MON_W-1:0]  nm;
  logic [YEAR_W-1:0] ny;
  logic [DIST_W-1:0] dist_r;
  logic [1:0]        st_r;

  logic              vld_c;
  logic [DN_W-1:0]   diff_c;
  logic [DIST_W-1:0] dist_c;
  logic [STEP_W-1:0] cnt_l;
  logic [SUM_W-1:0]  res_w;
  logic              back_sat;
  logic [DN_W-1:0]   res_c;
  logic              rng_c;
  logic [DAY_W-1:0]  mo_len;

  // ---- year unit: days before year yr, and leap flag of yr ----
  assign q      = qprod[QP_W-1:RECIP_100_SH];
  assign r      = yr - YR_W'(q) * YR_W'(7'd100);
  assign zr     = (r == '0);
  assign p100   = zr ? q - 1'b1 : q;
  assign p      = yr - 1'b1;
  assign dby_c  = DN_W'(p) * DN_W'(DAYS_YEAR) + DN_W'(p >> 2) - DN_W'(p100)
                + DN_W'(p100 >> 2);
  assign leap_c = ((yr[1:0] == 2'b00) && !zr) || (zr && (q[1:0] == 2'b00));

  always_ff @(posedge clk) begin
    qprod  <= QP_W'(yr) * QP_W'(RECIP_100);
    dby_r  <= dby_c;
    leap_r <= leap_c;
  end

  // ---- supplied date check and distance ----
  assign vld_c  = (y_r != '0) && (32'(y_r) <= MAX_YEAR) && (m_r != '0)
               && (m_r <= 4'(MONTHS)) && (d_r != '0) && (d_r <= month_days(m_r, leap_r));
  assign diff_c = (a_r > b_r) ? a_r - b_r : b_r - a_r;
  assign dist_c = (diff_c > DN_W'(DIST_MAX)) ? DIST_MAX : diff_c[DIST_W-1:0];

  // ---- move target ----
  always_comb begin
    cnt_l    = (STEP_W'(cnt_r) > STEP_LIM) ? STEP_LIM : STEP_W'(cnt_r);
    back_sat = 1'b0;
    if (mode_r == MODE_ADVANCE) begin
      res_w = SUM_W'(a_r) + SUM_W'(cnt_l);
    end else if (SUM_W'(cnt_l) >= SUM_W'(a_r)) begin
      res_w    = SUM_W'(1);
      back_sat = 1'b1;
    end else begin
      res_w = SUM_W'(a_r) - SUM_W'(cnt_l);
    end
    if (res_w > SUM_W'(DN_TOP)) begin
      res_c = DN_TOP;
      rng_c = 1'b1;
    end else begin
      res_c = res_w[DN_W-1:0];
      rng_c = back_sat;
    end
  end

  assign mo_len          = month_days(mo, leap_m);
  assign stat.is_move    = (mode_r == MODE_ADVANCE) || (mode_r == MODE_BACK);
  assign stat.found      = (dby_r >= dn);
  assign stat.month_done = (mo == 4'(MONTHS)) || (rem <= REM_W'(mo_len));

  // ---- working registers ----
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      mode_r <= mode_t'(mode);
      d_r    <= in_day;
      m_r    <= in_month;
      y_r    <= in_year;
      cnt_r  <= step_count;
    end

    case (cmd.yr_op)
      YR_IN:   yr <= YR_W'(in_year);
      YR_CUR:  yr <= YR_W'(cur_year);
      YR_EST:  yr <= YR_W'(eprod[EP_W-1:RECIP_YR_SH]) + YR_W'(2);
      YR_INC:  yr <= yr + 1'b1;
      YR_DEC:  yr <= yr - 1'b1;
      default: yr <= yr;
    endcase

    if (cmd.cap_b) begin
      b_r   <= day_number(dby_r, m_r, d_r, leap_r);
      vld_r <= vld_c;
    end
    if (cmd.cap_a) begin
      a_r <= day_number(dby_r, cur_month, cur_day, leap_r);
    end

    if (cmd.decide) begin
      case (mode_r)
        MODE_LOAD: begin
          nd     <= vld_r ? d_r : cur_day;
          nm     <= vld_r ? m_r : cur_month;
          ny     <= vld_r ? y_r : cur_year;
          dist_r <= '0;
          st_r   <= vld_r ? ST_OK : ST_INVALID;
        end
        MODE_DISTANCE: begin
          nd     <= cur_day;
          nm     <= cur_month;
          ny     <= cur_year;
          dist_r <= vld_r ? dist_c : '0;
          st_r   <= vld_r ? ST_OK : ST_INVALID;
        end
        default: begin
          dn     <= res_c;
          dist_r <= '0;
          st_r   <= rng_c ? ST_RANGE : ST_OK;
        end
      endcase
    end

    if (cmd.est_mul) begin
      eprod <= EP_W'(dn - 1'b1) * EP_W'(RECIP_YR);
    end

    if (cmd.month_init) begin
      rem    <= REM_W'(dn - dby_r);
      leap_m <= leap_r;
      mo     <= 4'd1;
    end else if (cmd.month_step) begin
      if (stat.month_done) begin
        nd <= rem[DAY_W-1:0];
        nm <= mo;
        ny <= yr[YEAR_W-1:0];
      end else begin
        rem <= rem - REM_W'(mo_len);
        mo  <= mo + 1'b1;
      end
    end

    if (cmd.publish) begin
      date_day   <= nd;
      date_month <= nm;
      date_year  <= ny;
      distance   <= dist_r;
      status     <= st_r;
    end
  end

  // Stored date
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_day   <= RST_DAY;
      cur_month <= RST_MONTH;
      cur_year  <= RST_YEAR;
    end else if (cmd.publish) begin
      cur_day   <= nd;
      cur_month <= nm;
      cur_year  <= ny;
    end
  end

  a_cur_calendar: assert property (@(posedge clk) disable iff (rst)
    (cur_month >= 4'd1) && (cur_month <= 4'(MONTHS)) && (cur_day >= 5'd1))
    else $error("stored date left the calendar");

  a_year_found: assert property (@(posedge clk) disable iff (rst)
    cmd.month_init |-> (dn > dby_r) && ((dn - dby_r) <= DN_W'(DAYS_LEAP)))
    else $error("year search ended on the wrong year");

  a_rsp_is_cur: assert property (@(posedge clk) disable iff (rst)
    cmd.publish |=> (date_day == cur_day) && (date_month == cur_month)
                    && (date_year == cur_year))
    else $error("reported date differs from stored date");

endmodule

// ===== hdl/gregorian_date_counter.sv =====
// Top level of the Gregorian date counter: command and response channels.
`timescale 1ns / 1ps

// Holds one Gregorian date (reset 1/1/2000) and takes one command word at a
// time: mode 0 loads in_day/in_month/in_year, mode 1 advances the date by
// step_count days, mode 2 goes back by step_count days, mode 3 reports the
// absolute day distance to the supplied date. Every response carries the
// stored date after the command and a status: 0 ok, 1 supplied date invalid
// (load ignored, distance 0), 2 move saturated at 1/1/1 or 31/12/MAX_YEAR.
// Leap years follow the 4/100/400 rule. The block takes one word at a time.
// The sequencer steps each word through the shared year unit (a registered
// reciprocal multiply, then the days-before-year sum): a load or distance
// command passes the supplied and the stored date through it, a move needs
// four or five such passes (supplied date, stored date, estimated year, at
// most one step up, then the found year) and then walks the months of the
// found year at one month per cycle. A finished response waits in the output
// register while the next word is accepted.
module gregorian_date_counter (
  input  logic                          clk,
  input  logic                          rst,
  // command channel
  input  logic                          cmd_valid,
  output logic                          cmd_stall,
  input  logic [1:0]                    mode,
  input  logic [gdc_pkg::DAY_W-1:0]     in_day,
  input  logic [gdc_pkg::MON_W-1:0]     in_month,
  input  logic [gdc_pkg::YEAR_W-1:0]    in_year,
  input  logic [gdc_pkg::CNT_W-1:0]     step_count,
  // response channel
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output logic [gdc_pkg::DAY_W-1:0]     date_day,
  output logic [gdc_pkg::MON_W-1:0]     date_month,
  output logic [gdc_pkg::YEAR_W-1:0]    date_year,
  output logic [gdc_pkg::DIST_W-1:0]    distance,
  output logic [1:0]                    status
);
  import gdc_pkg::*;

  gdc_cmd_t  cmd;
  gdc_stat_t stat;

  // Sequencer: accept a word, step it through the datapath, hand off the response
  gdc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  // Datapath: stored date, year unit, day numbers, response register
  gdc_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .mode       (mode),
    .in_day     (in_day),
    .in_month   (in_month),
    .in_year    (in_year),
    .step_count (step_count),
    .date_day   (date_day),
    .date_month (date_month),
    .date_year  (date_year),
    .distance   (distance),
    .status     (status)
  );

endmodule

// ===== tb/gregorian_date_counter_tb.sv =====
// Self-checking testbench for the Gregorian date counter: directed and random command words.
`timescale 1ns / 1ps

module gregorian_date_counter_tb;
  import gdc_pkg::*;

  localparam int WATCHDOG_LIMIT = 1500;  // cycles with no accepted word on either side
  localparam int HOLD_CYCLES    = 200;   // long response hold-off in the pressure phase

  typedef struct {
    mode_t             op;
    logic [DAY_W-1:0]  day;
    logic [MON_W-1:0]  month;
    logic [YEAR_W-1:0] year;
    logic [CNT_W-1:0]  count;
  } cmd_t;

  typedef struct {
    logic [DAY_W-1:0]  day;
    logic [MON_W-1:0]  month;
    logic [YEAR_W-1:0] year;
    logic [DIST_W-1:0] span;
    logic [1:0]        st;
  } rsp_t;

  typedef struct {
    int unsigned d;
    int unsigned m;
    int unsigned y;
  } date_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic              cmd_valid  = 1'b0;
  logic              cmd_stall;
  logic [1:0]        mode       = '0;
  logic [DAY_W-1:0]  in_day     = '0;
  logic [MON_W-1:0]  in_month   = '0;
  logic [YEAR_W-1:0] in_year    = '0;
  logic [CNT_W-1:0]  step_count = '0;

  logic              rsp_valid;
  logic              rsp_stall  = 1'b0;
  logic [DAY_W-1:0]  date_day;
  logic [MON_W-1:0]  date_month;
  logic [YEAR_W-1:0] date_year;
  logic [DIST_W-1:0] distance;
  logic [1:0]        status;

  logic cmd_taken = 1'b0;

  cmd_t cmd_backlog[$];
  rsp_t predicted_rsp[$];

  int errors        = 0;
  int send_idle_pct = 0;
  int rcv_stall_pct = 0;
  int holds_asked   = 0;
  int holds_served  = 0;
  int hold_left     = 0;
  int idle_cycles   = 0;

  // Shadow of the stored date
  int unsigned cal_day   = RST_DAY;
  int unsigned cal_month = RST_MONTH;
  int unsigned cal_year  = RST_YEAR;

  gregorian_date_counter u_dut (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_stall  (cmd_stall),
    .mode       (mode),
    .in_day     (in_day),
    .in_month   (in_month),
    .in_year    (in_year),
    .step_count (step_count),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .date_day   (date_day),
    .date_month (date_month),
    .date_year  (date_year),
    .distance   (distance),
    .status     (status)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------- calendar
  function automatic bit leap_year(int unsigned y);
    return (y % 400 == 0) || (y % 4 == 0 && y % 100 != 0);
  endfunction

  function automatic int unsigned month_length(int unsigned m, int unsigned y);
    case (m)
      2:             return leap_year(y) ? 29 : 28;
      4, 6, 9, 11:   return 30;
      default:       return 31;
    endcase
  endfunction

  function automatic bit date_ok(int unsigned d, int unsigned m, int unsigned y);
    if (y < 1 || y > MAX_YEAR) return 1'b0;
    if (m < 1 || m > MONTHS) return 1'b0;
    return d >= 1 && d <= month_length(m, y);
  endfunction

  // Days in all years before year y
  function automatic int unsigned years_to_days(int unsigned y);
    int unsigned p;
    p = y - 1;
    return p * DAYS_YEAR + p / 4 - p / 100 + p / 400;
  endfunction

  // Day index of a date, 1/1/1 is day 1
  function automatic int unsigned day_index(int unsigned d, int unsigned m, int unsigned y);
    int unsigned n;
    n = years_to_days(y);
    for (int unsigned k = 1; k < m && k <= MONTHS; k++) n += month_length(k, y);
    return n + d;
  endfunction

  function automatic date_t index_to_date(int unsigned dn);
    date_t dt;
    int unsigned rem;
    dt.y = (dn - 1) / DAYS_LEAP + 1;
    while (years_to_days(dt.y + 1) < dn) dt.y++;
    rem  = dn - years_to_days(dt.y);
    dt.m = 1;
    while (dt.m < MONTHS && rem > month_length(dt.m, dt.y)) begin
      rem -= month_length(dt.m, dt.y);
      dt.m++;
    end
    dt.d = rem;
    return dt;
  endfunction

  // Apply one command word to the shadow date and return the response it owes
  function automatic rsp_t apply_command(cmd_t c);
    rsp_t        r;
    date_t       dt;
    int unsigned a, b, diff, top, cur, res, cnt;
    r.span = '0;
    r.st   = ST_OK;
    case (c.op)
      MODE_LOAD: begin
        if (date_ok(c.day, c.month, c.year)) begin
          cal_day   = c.day;
          cal_month = c.month;
          cal_year  = c.year;
        end else begin
          r.st = ST_INVALID;
        end
      end
      MODE_DISTANCE: begin
        if (date_ok(c.day, c.month, c.year)) begin
          a    = day_index(cal_day, cal_month, cal_year);
          b    = day_index(c.day, c.month, c.year);
          diff = (a > b) ? a - b : b - a;
          if (diff > DIST_MAX) diff = DIST_MAX;
          r.span = DIST_W'(diff);
        end else begin
          r.st = ST_INVALID;
        end
      end
      default: begin
        top = day_index(31, MONTHS, MAX_YEAR);
        cur = day_index(cal_day, cal_month, cal_year);
        cnt = c.count;
        if (cnt > MAX_STEP) cnt = MAX_STEP;
        if (c.op == MODE_ADVANCE) begin
          res = cur + cnt;
        end else if (cnt >= cur) begin
          // clamp at the first day of year one
          res = 1;
          if (cnt > cur - 1) r.st = ST_RANGE;
        end else begin
          res = cur - cnt;
        end
        if (res > top) begin
          res  = top;
          r.st = ST_RANGE;
        end
        dt        = index_to_date(res);
        cal_day   = dt.d;
        cal_month = dt.m;
        cal_year  = dt.y;
      end
    endcase
    r.day   = DAY_W'(cal_day);
    r.month = MON_W'(cal_month);
    r.year  = YEAR_W'(cal_year);
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus
  task automatic queue_cmd(mode_t op, int unsigned d, int unsigned m, int unsigned y,
                           int unsigned cnt);
    cmd_t c;
    c.op    = op;
    c.day   = DAY_W'(d);
    c.month = MON_W'(m);
    c.year  = YEAR_W'(y);
    c.count = CNT_W'(cnt);
    cmd_backlog.push_back(c);
  endtask

  // Mostly well-formed dates near the interesting spots, a quarter raw noise
  function automatic cmd_t random_command();
    cmd_t        c;
    int unsigned y, m, len, d;
    c.op = mode_t'($urandom_range(3));
    if ($urandom_range(99) < 25) begin
      c.day   = DAY_W'($urandom);
      c.month = MON_W'($urandom);
      c.year  = YEAR_W'($urandom);
      c.count = CNT_W'($urandom);
    end else begin
      case ($urandom_range(9))
        0:       y = $urandom_range(3, 1);
        1:       y = $urandom_range(MAX_YEAR, MAX_YEAR - 2);
        2:       y = $urandom_range(99, 1) * 100;
        3:       y = 1996 + $urandom_range(12);
        default: y = $urandom_range(MAX_YEAR, 1);
      endcase
      m   = $urandom_range(MONTHS, 1);
      len = month_length(m, y);
      case ($urandom_range(7))
        0:       d = len;
        1:       d = 1;
        2:       d = len + 1;  // one past the month end
        default: d = $urandom_range(len, 1);
      endcase
      c.day   = DAY_W'(d);
      c.month = MON_W'(m);
      c.year  = YEAR_W'(y);
      case ($urandom_range(7))
        0:       c.count = CNT_W'($urandom_range(3));
        1:       c.count = CNT_W'(MAX_STEP);
        2:       c.count = CNT_W'($urandom);
        default: c.count = CNT_W'($urandom_range(2000));
      endcase
    end
    return c;
  endfunction

  // Hold the sender until every queued word went in and every response came back
  task automatic drain();
    while (cmd_backlog.size() != 0 || cmd_valid || predicted_rsp.size() != 0)
      @(posedge clk);
  endtask

  task automatic run_random(int s_pct, int r_pct, int n, bit pressure);
    send_idle_pct = s_pct;
    rcv_stall_pct = r_pct;
    if (pressure) holds_asked++;
    for (int i = 0; i < n; i++) cmd_backlog.push_back(random_command());
    drain();
  endtask

  task automatic check_field(string what, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, exp_v, act_v);
      errors++;
    end
  endtask

  // ---------------------------------------------------------------- driver
  // Offer a new word once the previous one went in; hold it while stalled.
  always @(negedge clk) begin
    cmd_t c;
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (!cmd_valid || cmd_taken) begin
      if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        c = cmd_backlog.pop_front();
        cmd_valid  <= 1'b1;
        mode       <= c.op;
        in_day     <= c.day;
        in_month   <= c.month;
        in_year    <= c.year;
        step_count <= c.count;
      end else begin
        cmd_valid <= 1'b0;
      end
    end
  end

  // Response stall: random, or one long hold-off when asked for
  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left--;
      rsp_stall <= 1'b1;
    end else if (holds_served != holds_asked) begin
      holds_served++;
      hold_left = HOLD_CYCLES;
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= ($urandom_range(99) < rcv_stall_pct);
    end
  end

  // ---------------------------------------------------------------- monitor
  always @(posedge clk) begin
    cmd_t c;
    rsp_t e;
    if (rst) begin
      cmd_taken <= 1'b0;
    end else begin
      cmd_taken <= cmd_valid && !cmd_stall;
      if (cmd_valid && !cmd_stall) begin
        c.op    = mode_t'(mode);
        c.day   = in_day;
        c.month = in_month;
        c.year  = in_year;
        c.count = step_count;
        predicted_rsp.push_back(apply_command(c));
      end
      if (rsp_valid && !rsp_stall) begin
        if (predicted_rsp.size() == 0) begin
          $display("%0t: response with no word pending, expected none, actual %0d/%0d/%0d",
                   $time, date_day, date_month, date_year);
          errors++;
        end else begin
          e = predicted_rsp.pop_front();
          check_field("date_day", e.day, date_day);
          check_field("date_month", e.month, date_month);
          check_field("date_year", e.year, date_year);
          check_field("distance", e.span, distance);
          check_field("status", e.st, status);
        end
      end
    end
  end

  // ---------------------------------------------------------------- watchdog
  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("gregorian_date_counter_tb: done, errors");
    $finish;
  end

  // ---------------------------------------------------------------- sequence
  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed words, no idling
    queue_cmd(MODE_DISTANCE, 1, 1, 2000, 0);      // zero distance to the reset date
    queue_cmd(MODE_LOAD, 1, 1, 1, 0);
    queue_cmd(MODE_BACK, 0, 0, 0, 0);
    queue_cmd(MODE_BACK, 0, 0, 0, 1);             // clamp at the bottom
    queue_cmd(MODE_ADVANCE, 0, 0, 0, MAX_STEP);
    queue_cmd(MODE_LOAD, 2, 1, 1, 0);
    queue_cmd(MODE_BACK, 0, 0, 0, 1);             // land on the bottom exactly
    queue_cmd(MODE_LOAD, 31, 12, MAX_YEAR, 0);
    queue_cmd(MODE_ADVANCE, 0, 0, 0, 0);
    queue_cmd(MODE_ADVANCE, 0, 0, 0, 1);          // clamp at the top
    queue_cmd(MODE_DISTANCE, 1, 1, 1, 0);         // widest distance
    queue_cmd(MODE_BACK, 31, 15, 16383, 16'hFFFF);
    queue_cmd(MODE_LOAD, 29, 2, 2000, 0);         // leap by the 400 rule
    queue_cmd(MODE_LOAD, 29, 2, 1900, 0);         // century, no leap
    queue_cmd(MODE_LOAD, 29, 2, 2023, 0);
    queue_cmd(MODE_LOAD, 28, 2, 2004, 0);
    queue_cmd(MODE_ADVANCE, 0, 0, 0, 1);
    queue_cmd(MODE_ADVANCE, 0, 0, 0, 1);
    queue_cmd(MODE_LOAD, 0, 1, 2000, 0);
    queue_cmd(MODE_LOAD, 31, 4, 2000, 0);
    queue_cmd(MODE_LOAD, 1, 13, 2000, 0);
    queue_cmd(MODE_LOAD, 1, 0, 2000, 0);
    queue_cmd(MODE_LOAD, 1, 1, 0, 0);
    queue_cmd(MODE_LOAD, 1, 1, MAX_YEAR + 1, 0);
    queue_cmd(MODE_DISTANCE, 31, 15, 16383, 0);   // invalid, distance stays zero
    queue_cmd(MODE_DISTANCE, 1, 1, 2400, 0);
    drain();

    // Random words under each idling mix, then the long hold-off
    run_random(0, 0, 85, 1'b0);
    run_random(52, 0, 85, 1'b0);
    run_random(0, 52, 85, 1'b0);
    run_random(12, 12, 85, 1'b0);
    run_random(0, 0, 85, 1'b1);

    repeat (40) @(posedge clk);
    if (predicted_rsp.size() != 0) begin
      $display("%0t: responses missing, expected %0d more, actual 0",
               $time, predicted_rsp.size());
      errors += predicted_rsp.size();
    end
    if (errors == 0)
      $display("gregorian_date_counter_tb: done, clean");
    else
      $display("gregorian_date_counter_tb: done, errors");
    $finish;
  end

endmodule

// ===== gregorian_date_counter.f =====
hdl/gdc_pkg.sv
hdl/gdc_ctrl.sv
hdl/gdc_datapath.sv
hdl/gregorian_date_counter.sv
tb/gregorian_date_counter_tb.sv
